@@ src/btpc_pkg.sv @@
package btpc_pkg;

  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 31;
  localparam int unsigned DivCells = NumW;

  localparam logic signed [31:0] TFINE_OFFSET = 32'sd128000;
  localparam logic [20:0]        PRESS_BASE   = 21'd1048576;
  localparam logic signed [63:0] PRESS_SCALE  = 64'sd3125;
  localparam logic signed [63:0] P1_BIAS      = 64'sh0000_8000_0000_0000;
  localparam int unsigned        P4_SHIFT     = 35;

  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;

  // One slot of the divider chain: partial remainder, dividend bits shifting
  // out at the top and quotient bits shifting in at the bottom.
  typedef struct packed {
    logic                valid;
    logic                dz;
    logic                neg;
    logic signed [23:0]  temp;
    logic [DenW-1:0]     den;
    logic [DenW-1:0]     rem;
    logic [NumW-1:0]     acc;
  } div_t;

endpackage

@@ src/baro_temp_press_compensation.sv @@
// Structure: a front pipeline, 64 divider cells of one quotient bit each and
// 5 back stages.
// Throughput: one item per cycle; the whole pipe advances unless a result
// waits untaken in the output register.
// Reset: asynchronous, active low; clears all valid bits and the calibration
// registers to zero.
module baro_temp_press_compensation import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // raw_temp[19:0], raw_press[39:20]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // temp_centideg[23:0], press_q24_8[55:24]
  output logic        m_axis_tuser_o,   // div_zero[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] temp_q, pa_q, pb_q, pc_q;
  logic        ce;
  logic        out_valid;
  logic signed [23:0] temp_out;
  logic [31:0] press_out;
  logic        dz_out;
  div_t        chain [DivCells+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEMP:    temp_q <= cfg_data_i;
        REG_PRESS_A: pa_q   <= cfg_data_i;
        REG_PRESS_B: pb_q   <= cfg_data_i;
        REG_PRESS_C: pc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ce              = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = ce;

  btpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ce_i          (ce),
    .in_valid_i    (s_axis_tvalid_i),
    .raw_temp_i    (s_axis_tdata_i[19:0]),
    .raw_press_i   (s_axis_tdata_i[39:20]),
    .temp_coeffs_i (temp_q),
    .press_a_i     (pa_q),
    .press_b_i     (pb_q),
    .div_o         (chain[0])
  );

  for (genvar g = 0; g < DivCells; g++) begin : g_div
    btpc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ce_i   (ce),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  btpc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ce_i      (ce),
    .div_i     (chain[DivCells]),
    .press_c_i (pc_q),
    .valid_o   (out_valid),
    .temp_o    (temp_out),
    .press_o   (press_out),
    .dz_o      (dz_out)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {press_out, temp_out};
  assign m_axis_tuser_o  = dz_out;

endmodule

@@ src/btpc_front.sv @@
module btpc_front import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ce_i,
  input  logic        in_valid_i,
  input  logic [19:0] raw_temp_i,
  input  logic [19:0] raw_press_i,
  input  logic [47:0] temp_coeffs_i,
  input  logic [47:0] press_a_i,
  input  logic [47:0] press_b_i,
  output div_t        div_o
);

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

  assign t1 = temp_coeffs_i[15:0];
  assign t2 = $signed(temp_coeffs_i[31:16]);
  assign t3 = $signed(temp_coeffs_i[47:32]);
  assign p1 = press_a_i[15:0];
  assign p2 = $signed(press_a_i[31:16]);
  assign p3 = $signed(press_a_i[47:32]);
  assign p4 = $signed(press_b_i[15:0]);
  assign p5 = $signed(press_b_i[31:16]);
  assign p6 = $signed(press_b_i[47:32]);

  logic [6:0] vld_q;

  logic signed [18:0] xt;
  logic signed [16:0] dt;
  logic signed [34:0] m1_q, m1_d;
  logic signed [33:0] dd_q, dd_d;
  logic [19:0]        ap1_q, ap2_q, ap3_q, ap4_q;
  logic signed [23:0] at_q, at_d;
  logic signed [38:0] b1_q, b1_d;
  logic signed [31:0] tf_q, tf_d;
  logic signed [31:0] ap_q, ap_d;
  logic signed [63:0] aa_q, aa_d;
  logic signed [35:0] tw;
  logic signed [23:0] tc_q, tc_d, tc5_q, tc6_q;
  logic signed [63:0] bt_q, bt_d, at5_q, at5_d;
  logic [20:0]        pd_q, pd_d;
  logic signed [63:0] den_full;
  logic signed [30:0] den_q;
  logic [63:0]        num_q, num_d;
  div_t               div_q, div_d;

  always_comb begin
    xt   = $signed({2'b00, raw_temp_i[19:3]}) - $signed({2'b00, t1, 1'b0});
    dt   = $signed({1'b0, raw_temp_i[19:4]}) - $signed({1'b0, t1});
    m1_d = xt * t2;
    dd_d = dt * dt;
    at_d = 24'(m1_q >>> 11);
    b1_d = (dd_q >>> 12) * t3;
    tf_d = 32'(at_q) + 32'(b1_q >>> 14);
    ap_d = tf_q - TFINE_OFFSET;
    aa_d = ap_d * ap_d;
    tw   = (tf_q * 36'sd5 + 36'sd128) >>> 8;
    if (tw > 36'sd8388607) begin
      tc_d = 24'sh7fffff;
    end else if (tw < -36'sd8388608) begin
      tc_d = 24'sh800000;
    end else begin
      tc_d = tw[23:0];
    end
    bt_d  = aa_q * p6 + ((ap_q * p5) <<< 17) + (p4 <<< P4_SHIFT);
    at5_d = ((aa_q * p3) >>> 8) + ((ap_q * p2) <<< 12);
    pd_d  = PRESS_BASE - {1'b0, ap4_q};
    den_full = (P1_BIAS + at5_q) * $signed({1'b0, p1});
    num_d = $unsigned(($signed(64'({pd_q, 31'b0})) - bt_q) * PRESS_SCALE);
    div_d       = '0;
    div_d.dz    = (den_q == '0);
    div_d.neg   = num_q[63] ^ den_q[30];
    div_d.temp  = tc6_q;
    div_d.den   = den_q[30] ? $unsigned(-den_q) : $unsigned(den_q);
    div_d.acc   = num_q[63] ? (-num_q) : num_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      m1_q  <= m1_d;
      dd_q  <= dd_d;
      ap1_q <= raw_press_i;
      at_q  <= at_d;
      b1_q  <= b1_d;
      ap2_q <= ap1_q;
      tf_q  <= tf_d;
      ap3_q <= ap2_q;
      ap_q  <= ap_d;
      aa_q  <= aa_d;
      tc_q  <= tc_d;
      ap4_q <= ap3_q;
      bt_q  <= bt_d;
      at5_q <= at5_d;
      pd_q  <= pd_d;
      tc5_q <= tc_q;
      den_q <= den_full[63:33];
      num_q <= num_d;
      tc6_q <= tc5_q;
      div_q <= div_d;
    end
  end

  always_comb begin
    div_o       = div_q;
    div_o.valid = vld_q[6];
  end

endmodule

@@ src/btpc_div_cell.sv @@
module btpc_div_cell import btpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ce_i,
  input  div_t cell_i,
  output div_t cell_o
);

  logic          vld_q;
  div_t          data_q, data_d;
  logic [DenW:0] r2, diff;
  logic          ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    r2   = {cell_i.rem, cell_i.acc[NumW-1]};
    diff = r2 - {1'b0, cell_i.den};
    ge   = (r2 >= {1'b0, cell_i.den});
    data_d     = cell_i;
    data_d.rem = ge ? diff[DenW-1:0] : r2[DenW-1:0];
    data_d.acc = {cell_i.acc[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ce_i) begin
      vld_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = vld_q;
  end

endmodule

@@ src/btpc_back.sv @@
module btpc_back import btpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ce_i,
  input  div_t               div_i,
  input  logic [47:0]        press_c_i,
  output logic               valid_o,
  output logic signed [23:0] temp_o,
  output logic [31:0]        press_o,
  output logic               dz_o
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = $signed(press_c_i[15:0]);
  assign p8 = $signed(press_c_i[31:16]);
  assign p9 = $signed(press_c_i[47:32]);

  logic [4:0]         vld_q;
  logic signed [23:0] t1_q, t2_q, t3_q, t4_q, temp_q;
  logic               z1_q, z2_q, z3_q, z4_q, dz_q;
  logic signed [63:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [63:0] s;
  logic [31:0]        lo, hi;
  logic [63:0]        lolo_q;
  logic [31:0]        lohi_q;
  logic signed [63:0] pb2_q, pb3_q, pb4_q;
  logic [63:0]        ss_q;
  logic signed [63:0] dt_q;
  logic signed [63:0] r;
  logic [31:0]        press_q, press_d;

  always_comb begin
    s  = p1_q >>> 13;
    lo = s[31:0];
    hi = s[63:32];
    r  = ((p4_q + (dt_q >>> 25) + (pb4_q >>> 19)) >>> 8) + (p7 <<< 4);
    if (z4_q || r < 64'sd0) begin
      press_d = '0;
    end else if (r > 64'sd4294967295) begin
      press_d = '1;
    end else begin
      press_d = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[3:0], div_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      p1_q   <= div_i.neg ? $signed(-div_i.acc) : $signed(div_i.acc);
      t1_q   <= div_i.temp;
      z1_q   <= div_i.dz;
      // Square of the shifted value, modulo 2^64, from 32-bit halves.
      lolo_q <= 64'(lo) * 64'(lo);
      lohi_q <= lo * hi;
      pb2_q  <= p1_q * p8;
      p2_q   <= p1_q;
      t2_q   <= t1_q;
      z2_q   <= z1_q;
      ss_q   <= lolo_q + {lohi_q[30:0], 1'b0, 32'd0};
      pb3_q  <= pb2_q;
      p3_q   <= p2_q;
      t3_q   <= t2_q;
      z3_q   <= z2_q;
      dt_q   <= $signed(ss_q) * p9;
      pb4_q  <= pb3_q;
      p4_q   <= p3_q;
      t4_q   <= t3_q;
      z4_q   <= z3_q;
      press_q <= press_d;
      temp_q  <= t4_q;
      dz_q    <= z4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign temp_o  = temp_q;
  assign press_o = press_q;
  assign dz_o    = dz_q;

endmodule

@@ src/btpc_checker.sv @@
module btpc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // A zero divisor always comes with zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[55:24] == 32'd0)
    else $error("div_zero without zero pressure");

  // The input side stops taking items while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("item taken while pipe stalled");

endmodule

bind baro_temp_press_compensation btpc_sva u_btpc_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
